FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file of the block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while reset is asserted
`define HTD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked while reset is asserted
`define HTD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication checked during reset as well
`define HTD_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/htd_pkg.sv
// ----------------------------------------------------------------------------
// htd_pkg
// Types, constants and codes shared by the Huffman tree decoder modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package htd_pkg;

  // field widths
  localparam int IDX_W  = 9;
  localparam int SYM_W  = 8;
  localparam int BYTE_W = 8;
  localparam int BITS_W = 4;

  // bits per compressed byte and the first bit taken
  localparam logic [BITS_W-1:0] BYTE_BITS = 4'd8;
  localparam int                TOP_BIT   = 7;

  // default node table depth
  localparam int NODE_COUNT_DEF = 512;

  // item operation codes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // configuration register index, taken from paddr[2]
  localparam logic REG_ROOT = 1'b0;

  // one node table entry: leaf flag, symbol, left child, right child
  typedef struct packed {
    logic             leaf;
    logic [SYM_W-1:0] sym;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
  } node_t;

  // node table access, one port: a write or a read per cycle
  typedef struct packed {
    logic             wr;
    logic             rd;
    logic [IDX_W-1:0] addr;
    node_t            wdata;
  } mem_req_t;

  // walker to output stage: a decoded symbol or the close of a byte
  typedef struct packed {
    logic             push;
    logic             close;
    logic [SYM_W-1:0] sym;
  } emit_t;

  // walker sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EVAL,
    ST_CHILD,
    ST_FLUSH
  } htd_state_t;

endpackage

FILE: rtl/htd_node_mem.sv
// ----------------------------------------------------------------------------
// htd_node_mem
// Node table: single-port synchronous memory with registered read latency
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module htd_node_mem
  import htd_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input  logic     clk,
  input  mem_req_t req,
  output node_t    rdata
);

  localparam int AW = $clog2(NODE_COUNT);

  node_t              mem [NODE_COUNT];
  logic [IDX_W+AW-1:0] addr_ext;
  logic [AW-1:0]       addr;
  logic                in_range;
  node_t               q_r;
  logic                ok_r;

  // map the node index onto the table address
  assign addr_ext = {{AW{1'b0}}, req.addr};
  assign addr     = addr_ext[AW-1:0];
  assign in_range = (32'(req.addr) < NODE_COUNT);

  // write port, writes beyond the table are dropped
  always_ff @(posedge clk) begin
    if (req.wr && in_range) begin
      mem[addr] <= req.wdata;
    end
  end

  // registered read, held until the next read
  always_ff @(posedge clk) begin
    if (req.rd) begin
      q_r  <= mem[addr];
      ok_r <= in_range;
    end
  end

  // an index beyond the table reads as an internal node with both children 0
  assign rdata = ok_r ? q_r : '0;

endmodule

FILE: rtl/htd_walker.sv
// ----------------------------------------------------------------------------
// htd_walker
// Tree walk sequencer: takes items, walks the node table bit by bit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module htd_walker
  import htd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_op,
  input  logic [IDX_W-1:0]  in_node_index,
  input  logic              in_node_is_leaf,
  input  logic [SYM_W-1:0]  in_node_symbol,
  input  logic [IDX_W-1:0]  in_left_child,
  input  logic [IDX_W-1:0]  in_right_child,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic [BITS_W-1:0] in_valid_bits,
  input  logic              in_end_of_stream,
  input  logic [IDX_W-1:0]  root,
  output mem_req_t          mem_req,
  input  node_t             mem_rdata,
  output emit_t             emit,
  input  logic              emit_ready
);

  htd_state_t          state_r, state_nxt;
  logic [IDX_W-1:0]    wp_r, wp_nxt;
  node_t               cur_r, cur_nxt;
  logic                cur_ok_r, cur_ok_nxt;
  logic [BYTE_W-1:0]   byte_r, byte_nxt;
  logic [BITS_W-1:0]   bits_r, bits_nxt;
  logic                eos_r, eos_nxt;
  node_t               ent;
  logic                bit_now;
  logic                more_bits;

  // entry under the pointer: cached copy in EVAL, fresh read otherwise
  assign ent       = (state_r == ST_EVAL) ? cur_r : mem_rdata;
  assign bit_now   = byte_r[TOP_BIT];
  assign more_bits = (bits_r > 4'd1);
  assign in_stall  = (state_r != ST_IDLE);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      wp_r     <= '0;
      cur_ok_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wp_r     <= wp_nxt;
      cur_ok_r <= cur_ok_nxt;
    end
  end

  // byte under decode and cached entry
  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    byte_r <= byte_nxt;
    bits_r <= bits_nxt;
    eos_r  <= eos_nxt;
  end

  // next state, table accesses and symbol hand-off
  always_comb begin
    state_nxt  = state_r;
    wp_nxt     = wp_r;
    cur_nxt    = cur_r;
    cur_ok_nxt = cur_ok_r;
    byte_nxt   = byte_r;
    bits_nxt   = bits_r;
    eos_nxt    = eos_r;
    mem_req    = '0;
    emit       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_WRITE) begin
            // node write, drop the cached entry
            mem_req.wr          = 1'b1;
            mem_req.addr        = in_node_index;
            mem_req.wdata.leaf  = in_node_is_leaf;
            mem_req.wdata.sym   = in_node_symbol;
            mem_req.wdata.left  = in_left_child;
            mem_req.wdata.right = in_right_child;
            cur_ok_nxt          = 1'b0;
          end else begin
            byte_nxt = in_data_byte;
            bits_nxt = (in_valid_bits > BYTE_BITS) ? BYTE_BITS : in_valid_bits;
            eos_nxt  = in_end_of_stream;
            if (in_valid_bits == '0) begin
              state_nxt = ST_FLUSH;
            end else if (cur_ok_r) begin
              state_nxt = ST_EVAL;
            end else begin
              mem_req.rd   = 1'b1;
              mem_req.addr = wp_r;
              state_nxt    = ST_FETCH;
            end
          end
        end
      end

      ST_FETCH, ST_EVAL: begin
        if (ent.leaf) begin
          // pointer stands on a leaf: emit it and take the bit
          emit.push = 1'b1;
          emit.sym  = ent.sym;
          if (emit_ready) begin
            byte_nxt   = byte_r << 1;
            bits_nxt   = bits_r - 4'd1;
            wp_nxt     = root;
            cur_ok_nxt = 1'b0;
            if (more_bits) begin
              mem_req.rd   = 1'b1;
              mem_req.addr = root;
              state_nxt    = ST_FETCH;
            end else begin
              state_nxt = ST_FLUSH;
            end
          end
        end else begin
          // step to the child chosen by the bit
          mem_req.rd   = 1'b1;
          mem_req.addr = bit_now ? ent.right : ent.left;
          wp_nxt       = mem_req.addr;
          cur_ok_nxt   = 1'b0;
          state_nxt    = ST_CHILD;
        end
      end

      ST_CHILD: begin
        if (mem_rdata.leaf) begin
          // landed on a leaf: emit and return to the root
          emit.push = 1'b1;
          emit.sym  = mem_rdata.sym;
          if (emit_ready) begin
            byte_nxt = byte_r << 1;
            bits_nxt = bits_r - 4'd1;
            wp_nxt   = root;
            if (more_bits) begin
              mem_req.rd   = 1'b1;
              mem_req.addr = root;
              state_nxt    = ST_FETCH;
            end else begin
              state_nxt = ST_FLUSH;
            end
          end
        end else begin
          // internal node: keep it as the cached entry
          byte_nxt   = byte_r << 1;
          bits_nxt   = bits_r - 4'd1;
          cur_nxt    = mem_rdata;
          cur_ok_nxt = 1'b1;
          state_nxt  = more_bits ? ST_EVAL : ST_FLUSH;
        end
      end

      ST_FLUSH: begin
        // mark the last symbol of the byte, apply end of stream
        emit.close = 1'b1;
        if (emit_ready) begin
          if (eos_r) begin
            wp_nxt     = root;
            cur_ok_nxt = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/htd_out_stage.sv
// ----------------------------------------------------------------------------
// htd_out_stage
// Holds one symbol until its last-of-byte flag is known, then registers it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module htd_out_stage
  import htd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  emit_t            emit,
  output logic             emit_ready,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [SYM_W-1:0] out_symbol,
  output logic             out_last_of_byte
);

  logic             pend_valid_r, pend_valid_nxt;
  logic [SYM_W-1:0] pend_sym_r, pend_sym_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0] out_sym_r, out_sym_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_free;
  logic             move;

  assign out_free = !out_valid_r || !out_stall;
  assign move     = pend_valid_r && (emit.push || emit.close) && out_free;

  // a held symbol must move out before the walker goes on
  assign emit_ready = !pend_valid_r || out_free;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    pend_sym_r <= pend_sym_nxt;
    out_sym_r  <= out_sym_nxt;
    out_last_r <= out_last_nxt;
  end

  // next values of the holding and output registers
  always_comb begin
    pend_valid_nxt = pend_valid_r;
    pend_sym_nxt   = pend_sym_r;
    out_valid_nxt  = out_valid_r;
    out_sym_nxt    = out_sym_r;
    out_last_nxt   = out_last_r;

    if (move) begin
      out_valid_nxt = 1'b1;
      out_sym_nxt   = pend_sym_r;
      out_last_nxt  = emit.close;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (emit.push && emit_ready) begin
      pend_valid_nxt = 1'b1;
      pend_sym_nxt   = emit.sym;
    end else if (emit.close && emit_ready) begin
      pend_valid_nxt = 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_symbol       = out_sym_r;
  assign out_last_of_byte = out_last_r;

endmodule

FILE: rtl/huffman_tree_decoder.sv
// ----------------------------------------------------------------------------
// huffman_tree_decoder
// Huffman bit-stream decoder walking a code tree held in a node table
// ----------------------------------------------------------------------------
//  port group   direction  handshake          payload
//  in_*         input      in_valid/in_stall  node write or compressed byte
//  out_*        output     out_valid/out_stall symbol, last_of_byte
//  cfg (APB)    input      psel/penable       root_node at byte address 0
//
//  A node write is taken while the walker is idle. A decode item holds the
//  input while the walker takes each valid bit (a bit taken while the
//  pointer is on a leaf needs no child read) and then closes the byte;
//  each tree step waits on the registered read of the node table.
//  Reset clears the walk pointer, root_node and the output valid flags; the
//  node table is not cleared. A stalled output holds the walk at its next
//  symbol while an item is in progress.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module huffman_tree_decoder
  import htd_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // item input
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_op,
  input  logic [IDX_W-1:0]  in_node_index,
  input  logic              in_node_is_leaf,
  input  logic [SYM_W-1:0]  in_node_symbol,
  input  logic [IDX_W-1:0]  in_left_child,
  input  logic [IDX_W-1:0]  in_right_child,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic [BITS_W-1:0] in_valid_bits,
  input  logic              in_end_of_stream,
  // result output
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SYM_W-1:0]  out_symbol,
  output logic              out_last_of_byte,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [IDX_W-1:0] root_r;
  mem_req_t         mem_req;
  node_t            mem_rdata;
  emit_t            emit;
  logic             emit_ready;

  // root_node register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ROOT)) begin
      root_r <= pwdata[IDX_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ROOT) ? {{(32-IDX_W){1'b0}}, root_r} : '0;

  // walk sequencer
  htd_walker u_walker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_node_index    (in_node_index),
    .in_node_is_leaf  (in_node_is_leaf),
    .in_node_symbol   (in_node_symbol),
    .in_left_child    (in_left_child),
    .in_right_child   (in_right_child),
    .in_data_byte     (in_data_byte),
    .in_valid_bits    (in_valid_bits),
    .in_end_of_stream (in_end_of_stream),
    .root             (root_r),
    .mem_req          (mem_req),
    .mem_rdata        (mem_rdata),
    .emit             (emit),
    .emit_ready       (emit_ready)
  );

  // node table
  htd_node_mem #(
    .NODE_COUNT (NODE_COUNT)
  ) u_node_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // output holding and register stage
  htd_out_stage u_out_stage (
    .clk              (clk),
    .rst_n            (rst_n),
    .emit             (emit),
    .emit_ready       (emit_ready),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_symbol       (out_symbol),
    .out_last_of_byte (out_last_of_byte)
  );

endmodule

FILE: rtl/htd_checker.sv
// ----------------------------------------------------------------------------
// htd_checker
// Port-level checks of the Huffman tree decoder, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module htd_checker
  import htd_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              in_op,
  input logic [BITS_W-1:0] in_valid_bits,
  input logic              out_valid,
  input logic              out_stall,
  input logic [SYM_W-1:0]  out_symbol,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [2:0]        paddr,
  input logic [31:0]       pwdata,
  input logic [31:0]       prdata
);

  // a stalled result stays offered with the same symbol
  `HTD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_symbol), "stalled result changed")

  // nothing is offered right after reset
  `HTD_ASSERT_NXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid, "result valid after reset")

  // a node write or an empty byte into an idle output produces no result
  `HTD_ASSERT_NXT(a_no_spurious, clk, rst_n, in_valid && !in_stall && !out_valid && ((in_op == OP_WRITE) || (in_valid_bits == '0)), !out_valid, "result from an item that yields none")

  // root_node reads back what was written
  `HTD_ASSERT_IMP(a_root_readback, clk, rst_n, (psel && penable && pwrite && (paddr[2] == REG_ROOT)) ##1 (paddr[2] == REG_ROOT), prdata[IDX_W-1:0] == $past(pwdata[IDX_W-1:0]), "root_node readback mismatch")

endmodule

bind huffman_tree_decoder htd_checker u_htd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_op         (in_op),
  .in_valid_bits (in_valid_bits),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_symbol    (out_symbol),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata)
);

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Huffman tree decoder: loads code trees into the
// node table, streams compressed bytes through the walker and compares every
// decoded symbol against a cycle-free walk of the same tree kept in the bench
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import htd_pkg::*;

  localparam int          ITEM_TARGET   = 250;
  localparam int          SETTLE_CYCLES = 40;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          STUCK_LIMIT   = 5000;
  localparam logic [2:0]  ROOT_ADDR     = {REG_ROOT, 2'b00};

  // one input item as the bench sees it
  typedef struct {
    logic              op;
    logic [IDX_W-1:0]  node_index;
    logic              is_leaf;
    logic [SYM_W-1:0]  node_sym;
    logic [IDX_W-1:0]  left;
    logic [IDX_W-1:0]  right;
    logic [BYTE_W-1:0] data;
    logic [BITS_W-1:0] nbits;
    logic              eos;
  } tree_item_t;

  // one decoded symbol
  typedef struct {
    logic [SYM_W-1:0] sym;
    logic             is_last;
  } sym_result_t;

  // tree walk predictor and the symbols still owed by the block
  class symbol_scoreboard;
    node_t            nodes [NODE_COUNT_DEF];
    logic [IDX_W-1:0] walk_ptr;
    logic [IDX_W-1:0] root_idx;
    sym_result_t      expected_symbols [$];
    int               errors;

    function new();
      foreach (nodes[i]) nodes[i] = '0;
      walk_ptr = '0;
      root_idx = '0;
      errors   = 0;
    endfunction

    function void set_root(input logic [IDX_W-1:0] v);
      root_idx = v;
    endfunction

    function int pending();
      return expected_symbols.size();
    endfunction

    // walk the tree for an accepted item and queue the symbols it yields
    function void note_item(input tree_item_t it);
      sym_result_t      found [$];
      sym_result_t      r;
      node_t            cur;
      node_t            nxt_e;
      logic [IDX_W-1:0] nxt;
      logic             emit;
      logic [SYM_W-1:0] s;
      int               nb;
      if (it.op == OP_WRITE) begin
        nodes[it.node_index].leaf  = it.is_leaf;
        nodes[it.node_index].sym   = it.node_sym;
        nodes[it.node_index].left  = it.left;
        nodes[it.node_index].right = it.right;
        return;
      end
      nb = (it.nbits > BYTE_BITS) ? int'(BYTE_BITS) : int'(it.nbits);
      for (int i = 0; i < nb; i++) begin
        cur = nodes[walk_ptr];
        // pointer parked on a leaf: the bit just emits that leaf
        if (cur.leaf) begin
          emit = 1'b1;
          s    = cur.sym;
        end else begin
          nxt      = it.data[TOP_BIT - i] ? cur.right : cur.left;
          nxt_e    = nodes[nxt];
          walk_ptr = nxt;
          emit     = nxt_e.leaf;
          s        = nxt_e.sym;
        end
        if (emit) begin
          r.sym     = s;
          r.is_last = 1'b0;
          found.insert(found.size(), r);
          walk_ptr = root_idx;
        end
      end
      if (found.size() > 0) found[found.size()-1].is_last = 1'b1;
      foreach (found[i]) expected_symbols.insert(expected_symbols.size(), found[i]);
      if (it.eos) walk_ptr = root_idx;
    endfunction

    // compare one accepted symbol with the oldest one owed
    function void check_symbol(input logic [SYM_W-1:0] sym, input logic is_last);
      sym_result_t want;
      if (expected_symbols.size() == 0) begin
        errors++;
        $display("%0t: unexpected symbol: expected none, actual %h (last %b)",
                 $time, sym, is_last);
        return;
      end
      want = expected_symbols[0];
      expected_symbols.delete(0);
      if (want.sym !== sym) begin
        errors++;
        $display("%0t: symbol mismatch: expected %h, actual %h", $time, want.sym, sym);
      end
      if (want.is_last !== is_last) begin
        errors++;
        $display("%0t: last_of_byte mismatch: expected %b, actual %b",
                 $time, want.is_last, is_last);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_op;
  logic [IDX_W-1:0]  in_node_index;
  logic              in_node_is_leaf;
  logic [SYM_W-1:0]  in_node_symbol;
  logic [IDX_W-1:0]  in_left_child;
  logic [IDX_W-1:0]  in_right_child;
  logic [BYTE_W-1:0] in_data_byte;
  logic [BITS_W-1:0] in_valid_bits;
  logic              in_end_of_stream;
  logic              out_valid;
  logic              out_stall;
  logic [SYM_W-1:0]  out_symbol;
  logic              out_last_of_byte;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  symbol_scoreboard  sb;
  bit                node_written [NODE_COUNT_DEF];
  bit                quiet;
  bit                burst_mode;
  bit                hold_req;
  int                items_sent;
  int                stuck_cycles;
  int                phase;
  int                nleaf;
  int                ndec;
  logic [IDX_W-1:0]  tree_top;

  huffman_tree_decoder u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_node_index    (in_node_index),
    .in_node_is_leaf  (in_node_is_leaf),
    .in_node_symbol   (in_node_symbol),
    .in_left_child    (in_left_child),
    .in_right_child   (in_right_child),
    .in_data_byte     (in_data_byte),
    .in_valid_bits    (in_valid_bits),
    .in_end_of_stream (in_end_of_stream),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_symbol       (out_symbol),
    .out_last_of_byte (out_last_of_byte),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // item builders: unused fields get random values
  function automatic tree_item_t node_item(input logic [IDX_W-1:0] idx, input logic leaf,
                                           input logic [SYM_W-1:0] sym,
                                           input logic [IDX_W-1:0] l,
                                           input logic [IDX_W-1:0] r);
    tree_item_t it;
    it.op         = OP_WRITE;
    it.node_index = idx;
    it.is_leaf    = leaf;
    it.node_sym   = sym;
    it.left       = l;
    it.right      = r;
    it.data       = BYTE_W'($urandom_range(0, 255));
    it.nbits      = BITS_W'($urandom_range(0, 15));
    it.eos        = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic tree_item_t byte_item(input logic [BYTE_W-1:0] d,
                                           input logic [BITS_W-1:0] nb, input logic e);
    tree_item_t it;
    it.op         = OP_DECODE;
    it.node_index = IDX_W'($urandom_range(0, 511));
    it.is_leaf    = 1'($urandom_range(0, 1));
    it.node_sym   = SYM_W'($urandom_range(0, 255));
    it.left       = IDX_W'($urandom_range(0, 511));
    it.right      = IDX_W'($urandom_range(0, 511));
    it.data       = d;
    it.nbits      = nb;
    it.eos        = e;
    return it;
  endfunction

  function automatic tree_item_t random_byte();
    logic [BITS_W-1:0] nb;
    nb = ($urandom_range(0, 3) != 0) ? BYTE_BITS : BITS_W'($urandom_range(0, 15));
    return byte_item(BYTE_W'($urandom_range(0, 255)), nb, $urandom_range(0, 7) == 0);
  endfunction

  // overwrite some node; children only point at written entries
  function automatic tree_item_t noise_node();
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] l;
    logic [IDX_W-1:0] r;
    idx = IDX_W'($urandom_range(0, 511));
    do l = IDX_W'($urandom_range(0, 511)); while (!node_written[l]);
    do r = IDX_W'($urandom_range(0, 511)); while (!node_written[r]);
    return node_item(idx, 1'($urandom_range(0, 1)), SYM_W'($urandom_range(0, 255)), l, r);
  endfunction

  // present one item, wait for acceptance, then maybe leave a gap
  task automatic send_item(input tree_item_t it);
    in_valid         <= 1'b1;
    in_op            <= it.op;
    in_node_index    <= it.node_index;
    in_node_is_leaf  <= it.is_leaf;
    in_node_symbol   <= it.node_sym;
    in_left_child    <= it.left;
    in_right_child   <= it.right;
    in_data_byte     <= it.data;
    in_valid_bits    <= it.nbits;
    in_end_of_stream <= it.eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(it);
    if (it.op == OP_WRITE) node_written[it.node_index] = 1'b1;
    items_sent++;
    if (!quiet && !burst_mode && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // stop sending, wait for every owed symbol, then let the walker go quiet
  task automatic drain_and_wait();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write root_node over the config port and read it back
  task automatic write_root(input logic [IDX_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ROOT_ADDR;
    pwdata  <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_root(v);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== 32'(v)) begin
      sb.errors++;
      $display("%0t: root_node readback mismatch: expected %h, actual %h",
               $time, 32'(v), prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // random code tree: leaves first, then merges, so children always exist
  task automatic build_tree(input int leaves, output logic [IDX_W-1:0] top);
    logic [IDX_W-1:0] pool [$];
    bit               taken [NODE_COUNT_DEF];
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    int               k;
    for (int i = 0; i < leaves; i++) begin
      do idx = IDX_W'($urandom_range(0, 511)); while (taken[idx]);
      taken[idx] = 1'b1;
      send_item(node_item(idx, 1'b1, SYM_W'($urandom_range(0, 255)),
                          IDX_W'($urandom_range(0, 511)), IDX_W'($urandom_range(0, 511))));
      pool.insert(pool.size(), idx);
    end
    while (pool.size() > 1) begin
      k = $urandom_range(0, pool.size() - 1);
      a = pool[k];
      pool.delete(k);
      k = $urandom_range(0, pool.size() - 1);
      b = pool[k];
      pool.delete(k);
      do idx = IDX_W'($urandom_range(0, 511)); while (taken[idx]);
      taken[idx] = 1'b1;
      send_item(node_item(idx, 1'b0, SYM_W'($urandom_range(0, 255)), a, b));
      pool.insert(pool.size(), idx);
    end
    top = pool[0];
  endtask

  // result side: random stall bursts, one long hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_symbol(out_symbol, out_last_of_byte);
  end

  // watchdog on cycles with no traffic anywhere
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles = stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    sb               = new();
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_op            = OP_WRITE;
    in_node_index    = '0;
    in_node_is_leaf  = 1'b0;
    in_node_symbol   = '0;
    in_left_child    = '0;
    in_right_child   = '0;
    in_data_byte     = '0;
    in_valid_bits    = '0;
    in_end_of_stream = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    quiet            = 1'b0;
    burst_mode       = 1'b0;
    hold_req         = 1'b0;
    items_sent       = 0;
    stuck_cycles     = 0;
    phase            = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // root is a leaf: every bit emits it, full byte, empty byte, too many bits
    send_item(node_item(9'd0, 1'b1, 8'hFF, 9'd511, 9'd0));
    send_item(byte_item(8'h00, BYTE_BITS, 1'b0));
    send_item(byte_item(8'h5A, 4'd0, 1'b0));
    send_item(byte_item(8'hFF, 4'd15, 1'b0));

    // small fixed tree rooted at the top index
    send_item(node_item(9'd1, 1'b1, 8'h00, 9'd0, 9'd0));
    send_item(node_item(9'd3, 1'b1, 8'h41, 9'd0, 9'd0));
    send_item(node_item(9'd4, 1'b1, 8'h42, 9'd0, 9'd0));
    send_item(node_item(9'd2, 1'b0, 8'h00, 9'd3, 9'd4));
    send_item(node_item(9'd511, 1'b0, 8'h00, 9'd1, 9'd2));
    drain_and_wait();
    write_root(9'd511);

    // pointer still parked on the old leaf root, then normal decode
    send_item(byte_item(8'b0110_1011, BYTE_BITS, 1'b0));
    // code split across bytes
    send_item(byte_item(8'h80, 4'd1, 1'b0));
    send_item(byte_item(8'h40, 4'd1, 1'b0));
    // end of stream drops a partial code
    send_item(byte_item(8'h80, 4'd1, 1'b1));
    send_item(byte_item(8'h00, 4'd1, 1'b0));
    // root change mid-code takes effect at the next return to root
    send_item(byte_item(8'h80, 4'd1, 1'b0));
    drain_and_wait();
    write_root(9'd0);
    send_item(byte_item(8'hC0, 4'd2, 1'b0));
    drain_and_wait();
    write_root(9'd511);
    send_item(byte_item(8'hFF, BYTE_BITS, 1'b1));

    // random trees, each followed by a run of compressed bytes
    while (items_sent < ITEM_TARGET) begin
      drain_and_wait();
      nleaf = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 16);
      build_tree(nleaf, tree_top);
      if ($urandom_range(0, 3) == 0) send_item(noise_node());
      drain_and_wait();
      write_root(tree_top);
      if (items_sent > ITEM_TARGET - 50) quiet = 1'b1;
      // one phase runs back to back into a long output hold
      if (phase == 2) begin
        burst_mode = 1'b1;
        hold_req   = 1'b1;
        ndec       = 40;
      end else begin
        ndec = $urandom_range(8, 24);
      end
      repeat (ndec) send_item(random_byte());
      burst_mode = 1'b0;
      phase++;
    end

    drain_and_wait();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
